### rtl/clps_pkg.sv
package clps_pkg;

    // List capacity and derived widths.
    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 6;
    localparam int ST_W     = 2;
    localparam int LEN_W    = 7;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_ADD_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_ADD_AT    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DEL_AT    = 3'd5;
    localparam logic [FUNC_W-1:0] FN_DUMP      = 3'd6;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_INS,
        S_RESP,
        S_DRD,
        S_DOUT
    } t_state;

endpackage

### rtl/clps_if.sv
// Command channel.
interface clps_in_if;
    logic                                valid;
    logic                                ready;
    logic [clps_pkg::FUNC_W-1:0]         func;
    logic [clps_pkg::POS_W-1:0]          position;
    logic signed [clps_pkg::DATA_W-1:0]  data_value;

    modport source (output valid, func, position, data_value, input ready);
    modport sink   (input valid, func, position, data_value, output ready);
endinterface

// Result channel.
interface clps_out_if;
    logic                                valid;
    logic                                ready;
    logic [clps_pkg::ST_W-1:0]           status;
    logic signed [clps_pkg::DATA_W-1:0]  element;
    logic [clps_pkg::LEN_W-1:0]          length;
    logic                                last;

    modport source (output valid, status, element, length, last, input ready);
    modport sink   (input valid, status, element, length, last, output ready);
endinterface

### rtl/clps_ram.sv
module clps_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/circular_list_position_store.sv
// An edit reads and writes back each element shifted by the insert or delete, then responds.
// A dump gives one beat per element, one memory read per element.
// The element memory, read then written back per moved entry, sets the pace.
// One command is handled at a time; a new beat is taken once all results are queued.
// Synchronous active-low reset clears the length and the sequencer; memory is not cleared.
module circular_list_position_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clps_in_if.sink     i_in,
    clps_out_if.source  o_out
);

    localparam int AW = clps_pkg::ADDR_W;
    localparam int CW = clps_pkg::CNT_W;
    localparam int XW = clps_pkg::CNT_W + 1;

    clps_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [AW-1:0]    r_idx, n_idx;
    logic [clps_pkg::DATA_W-1:0] r_val, n_val;
    logic             r_del, n_del;
    logic [clps_pkg::ST_W-1:0]   r_st, n_st;

    logic             r_ov, n_ov;
    logic [clps_pkg::ST_W-1:0]   r_ost, n_ost;
    logic [clps_pkg::DATA_W-1:0] r_oel, n_oel;
    logic [clps_pkg::LEN_W-1:0]  r_olen, n_olen;
    logic             r_olast, n_olast;

    logic             we, re;
    logic [AW-1:0]    waddr, raddr;
    logic [clps_pkg::DATA_W-1:0] wdata, rdata;
    logic             slot_free;
    logic [clps_pkg::LEN_W-1:0]  pos7, cnt7;
    logic [XW-1:0]    ptr_x, cnt_x, idx_x;
    logic [AW-1:0]    sel_idx;

    clps_ram #(
        .DEPTH(clps_pkg::CAPACITY),
        .WIDTH(clps_pkg::DATA_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign slot_free = !r_ov || o_out.ready;
    assign pos7  = clps_pkg::LEN_W'(i_in.position);
    assign cnt7  = clps_pkg::LEN_W'(r_count);
    assign ptr_x = XW'(r_ptr);
    assign cnt_x = XW'(r_count);
    assign idx_x = XW'(r_idx);

    assign i_in.ready    = (r_state == clps_pkg::S_IDLE);
    assign o_out.valid   = r_ov;
    assign o_out.status  = r_ost;
    assign o_out.element = r_oel;
    assign o_out.length  = r_olen;
    assign o_out.last    = r_olast;

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clps_pkg::S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_idx   <= n_idx;
        r_val   <= n_val;
        r_del   <= n_del;
        r_st    <= n_st;
        r_ost   <= n_ost;
        r_oel   <= n_oel;
        r_olen  <= n_olen;
        r_olast <= n_olast;
    end

    // Sequencer: decode, shift entries one at a time, then respond.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ptr   = r_ptr;
        n_idx   = r_idx;
        n_val   = r_val;
        n_del   = r_del;
        n_st    = r_st;
        n_ov    = r_ov && !o_out.ready;
        n_ost   = r_ost;
        n_oel   = r_oel;
        n_olen  = r_olen;
        n_olast = r_olast;
        we      = 1'b0;
        re      = 1'b0;
        waddr   = r_ptr;
        raddr   = r_ptr;
        wdata   = rdata;
        sel_idx = '0;

        case (r_state)
            clps_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_st  = clps_pkg::ST_OK;
                    n_val = i_in.data_value;
                    case (i_in.func)
                        clps_pkg::FN_ADD_FRONT, clps_pkg::FN_ADD_BACK,
                        clps_pkg::FN_ADD_AT: begin
                            if (i_in.func == clps_pkg::FN_ADD_AT &&
                                (pos7 == '0 || pos7 > cnt7 + 1'b1)) begin
                                n_st    = clps_pkg::ST_BADPOS;
                                n_state = clps_pkg::S_RESP;
                            end else if (cnt7 >= clps_pkg::LEN_W'(clps_pkg::CAPACITY)) begin
                                n_st    = clps_pkg::ST_FULL;
                                n_state = clps_pkg::S_RESP;
                            end else begin
                                if (i_in.func == clps_pkg::FN_ADD_FRONT) begin
                                    sel_idx = '0;
                                end else if (i_in.func == clps_pkg::FN_ADD_BACK) begin
                                    sel_idx = AW'(r_count);
                                end else begin
                                    sel_idx = AW'(pos7 - 1'b1);
                                end
                                n_idx   = sel_idx;
                                n_ptr   = AW'(r_count);
                                n_del   = 1'b0;
                                n_state = (AW'(r_count) == sel_idx) ? clps_pkg::S_INS
                                                                    : clps_pkg::S_RD;
                            end
                        end
                        clps_pkg::FN_DEL_FRONT, clps_pkg::FN_DEL_BACK,
                        clps_pkg::FN_DEL_AT: begin
                            if (i_in.func == clps_pkg::FN_DEL_AT &&
                                (pos7 == '0 || pos7 > cnt7)) begin
                                n_st    = clps_pkg::ST_BADPOS;
                                n_state = clps_pkg::S_RESP;
                            end else if (r_count == '0) begin
                                n_st    = clps_pkg::ST_EMPTY;
                                n_state = clps_pkg::S_RESP;
                            end else begin
                                if (i_in.func == clps_pkg::FN_DEL_FRONT) begin
                                    sel_idx = '0;
                                end else if (i_in.func == clps_pkg::FN_DEL_BACK) begin
                                    sel_idx = AW'(cnt7 - 1'b1);
                                end else begin
                                    sel_idx = AW'(pos7 - 1'b1);
                                end
                                n_idx   = sel_idx;
                                n_ptr   = sel_idx;
                                n_del   = 1'b1;
                                n_state = (XW'(sel_idx) + 1'b1 == cnt_x) ? clps_pkg::S_INS
                                                                         : clps_pkg::S_RD;
                            end
                        end
                        clps_pkg::FN_DUMP: begin
                            if (r_count == '0) begin
                                n_st    = clps_pkg::ST_EMPTY;
                                n_state = clps_pkg::S_RESP;
                            end else begin
                                n_ptr   = '0;
                                n_state = clps_pkg::S_DRD;
                            end
                        end
                        default: begin
                            n_state = clps_pkg::S_RESP;
                        end
                    endcase
                end
            end
            // Read the neighbor entry that moves into r_ptr.
            clps_pkg::S_RD: begin
                re      = 1'b1;
                raddr   = r_del ? AW'(ptr_x + 1'b1) : AW'(ptr_x - 1'b1);
                n_state = clps_pkg::S_WR;
            end
            // Write it back one place over.
            clps_pkg::S_WR: begin
                we    = 1'b1;
                waddr = r_ptr;
                wdata = rdata;
                if (r_del) begin
                    n_ptr   = AW'(ptr_x + 1'b1);
                    n_state = (ptr_x + 2'd2 == cnt_x) ? clps_pkg::S_INS : clps_pkg::S_RD;
                end else begin
                    n_ptr   = AW'(ptr_x - 1'b1);
                    n_state = (ptr_x - 1'b1 == idx_x) ? clps_pkg::S_INS : clps_pkg::S_RD;
                end
            end
            // Place the new value, or drop the tail, and update the length.
            clps_pkg::S_INS: begin
                if (r_del) begin
                    n_count = r_count - 1'b1;
                end else begin
                    we      = 1'b1;
                    waddr   = r_idx;
                    wdata   = r_val;
                    n_count = r_count + 1'b1;
                end
                n_state = clps_pkg::S_RESP;
            end
            // Single status beat.
            clps_pkg::S_RESP: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_ost   = r_st;
                    n_oel   = '0;
                    n_olen  = cnt7;
                    n_olast = 1'b1;
                    n_state = clps_pkg::S_IDLE;
                end
            end
            // Dump: fetch one element.
            clps_pkg::S_DRD: begin
                re      = 1'b1;
                raddr   = r_ptr;
                n_state = clps_pkg::S_DOUT;
            end
            // Dump: emit it once the output slot is free.
            clps_pkg::S_DOUT: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_ost   = clps_pkg::ST_OK;
                    n_oel   = rdata;
                    n_olen  = cnt7;
                    n_olast = (ptr_x + 1'b1 == cnt_x);
                    n_ptr   = AW'(ptr_x + 1'b1);
                    n_state = (ptr_x + 1'b1 == cnt_x) ? clps_pkg::S_IDLE : clps_pkg::S_DRD;
                end
            end
            default: begin
                n_state = clps_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The length never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(clps_pkg::CAPACITY))
        else $error("list length above capacity");

    // Memory writes happen only while shifting or placing a value.
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == clps_pkg::S_WR || r_state == clps_pkg::S_INS))
        else $error("memory write outside an edit");

    // An accepted command always leaves the idle state.
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_state != clps_pkg::S_IDLE)
        else $error("accepted command not started");

    // Length changes only when an edit completes.
    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> $past(r_state) == clps_pkg::S_INS)
        else $error("length changed outside an edit");
`endif

endmodule
